// File: rtl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared types and constants of the context bit probability estimator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

    // default geometry
    localparam int CONTEXT_BITS_DEF = 4;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH      = 4;

    // widest context and count that the classified item and the job can carry
    localparam int CTX_MAX_BITS = 12;
    localparam int CNT_MAX_W    = 32;

    // result field widths
    localparam int PROB_W    = 14;
    localparam int CTX_OUT_W = 4;
    localparam int CNT_OUT_W = 16;
    localparam int TOT_OUT_W = 17;

    localparam int PROB_SCALE = 10000;
    localparam int PROB_HALF  = 5000;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int CFG_W      = 8;
    localparam logic [CFG_W-1:0] INIT_COUNT_RST = 8'd1;
    localparam logic [APB_ADDR_W-3:0] REG_INITIAL_COUNT = 1'b0;

    typedef struct packed {
        logic bit_value;
        logic new_sequence;
    } t_in_item;

    typedef struct packed {
        logic [PROB_W-1:0]    probability_hundredths;
        logic                 warming_up;
        logic [CTX_OUT_W-1:0] context_code;
        logic [CNT_OUT_W-1:0] count_of_digit;
        logic [TOT_OUT_W-1:0] count_total;
    } t_out_item;

    // item after the front has classified it
    typedef struct packed {
        logic                    bit_value;
        logic                    new_sequence;
        logic                    warm;
        logic [CTX_MAX_BITS-1:0] ctx;
    } t_cls_item;

    // lookup result handed from the count table to the divider
    typedef struct packed {
        logic                    warm;
        logic [CTX_MAX_BITS-1:0] ctx;
        logic [CNT_MAX_W-1:0]    cnt;
        logic [CNT_MAX_W:0]      tot;
    } t_job;

endpackage

// File: rtl/cbpe_stream_if.sv
// ----------------------------------------------------------------------------
// cbpe_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface cbpe_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/cbpe_front.sv
// ----------------------------------------------------------------------------
// cbpe_front
// Tracks the digit history and tags each item as warm-up or full context.
// ----------------------------------------------------------------------------
module cbpe_front #(
    parameter int CONTEXT_BITS = cbpe_pkg::CONTEXT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbpe_pkg::t_in_item   i_item,
    input  logic                 i_valid,
    output logic                 o_ready,
    output cbpe_pkg::t_cls_item  o_cls,
    output logic                 o_valid,
    input  logic                 i_ready
);
    localparam int FILL_W = $clog2(CONTEXT_BITS + 1);

    logic [CONTEXT_BITS-1:0] r_hist, n_hist, hist_eff;
    logic [FILL_W-1:0]       r_fill, n_fill, fill_eff;
    logic                    warm;
    logic                    accept;

    always_comb begin
        hist_eff = i_item.new_sequence ? '0 : r_hist;
        fill_eff = i_item.new_sequence ? '0 : r_fill;
        warm     = fill_eff < FILL_W'(CONTEXT_BITS);
        n_fill   = warm ? fill_eff + FILL_W'(1) : fill_eff;
        // newest digit enters at the msb
        n_hist   = (hist_eff >> 1) |
                   (CONTEXT_BITS'(i_item.bit_value) << (CONTEXT_BITS - 1));
    end

    assign accept  = i_valid && i_ready;
    assign o_ready = i_ready;
    assign o_valid = i_valid;

    always_comb begin
        o_cls.bit_value    = i_item.bit_value;
        o_cls.new_sequence = i_item.new_sequence;
        o_cls.warm         = warm;
        o_cls.ctx          = warm ? '0 : cbpe_pkg::CTX_MAX_BITS'(hist_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_fill <= '0;
        end else if (accept) begin
            r_hist <= n_hist;
            r_fill <= n_fill;
        end
    end

endmodule

// File: rtl/cbpe_fifo.sv
// ----------------------------------------------------------------------------
// cbpe_fifo
// Short queue between the classifying front and the counting back end.
// ----------------------------------------------------------------------------
module cbpe_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = cbpe_pkg::QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  T     i_data,
    input  logic i_valid,
    output logic o_ready,
    output T     o_data,
    output logic o_valid,
    input  logic i_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           push, pop;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: rtl/cbpe_table.sv
// ----------------------------------------------------------------------------
// cbpe_table
// Zero and one count memories: restore sweep and read-modify-write per full-context item.
// ----------------------------------------------------------------------------
module cbpe_table #(
    parameter int CONTEXT_BITS = cbpe_pkg::CONTEXT_BITS_DEF,
    parameter int COUNT_WIDTH  = cbpe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cbpe_pkg::CFG_W-1:0] i_init_count,
    input  cbpe_pkg::t_cls_item        i_cls,
    input  logic                       i_valid,
    output logic                       o_ready,
    output cbpe_pkg::t_job             o_job,
    output logic                       o_valid,
    input  logic                       i_ready
);
    localparam int DEPTH = 1 << CONTEXT_BITS;

    typedef enum logic {S_IDLE, S_CALC} t_state;

    logic [COUNT_WIDTH-1:0]  r_zero_mem [DEPTH];
    logic [COUNT_WIDTH-1:0]  r_one_mem  [DEPTH];
    logic [COUNT_WIDTH-1:0]  r_rd_zero, r_rd_one;

    t_state                  r_state;
    logic                    r_bit;
    logic [CONTEXT_BITS-1:0] r_ctx;
    logic                    r_job_valid;
    cbpe_pkg::t_job          r_job;

    logic                    r_sweep_busy;
    logic [CONTEXT_BITS-1:0] r_sweep_idx;
    logic [COUNT_WIDTH-1:0]  r_sweep_base;

    logic                    job_free, pop, fire_calc;
    logic [CONTEXT_BITS-1:0] rd_addr, waddr;
    logic [COUNT_WIDTH-1:0]  cnt, n_cnt, wd_zero, wd_one;
    logic [COUNT_WIDTH:0]    tot;
    logic                    we_zero, we_one;

    assign job_free  = !r_job_valid || i_ready;
    // full-context items wait for the restore sweep, warm-up ones do not
    assign o_ready   = (r_state == S_IDLE) && (i_cls.warm ? job_free : !r_sweep_busy);
    assign pop       = i_valid && o_ready;
    assign fire_calc = (r_state == S_CALC) && job_free;
    // keep reading the same context while the lookup waits for the divider
    assign rd_addr   = (r_state == S_CALC) ? r_ctx : CONTEXT_BITS'(i_cls.ctx);

    always_comb begin
        cnt   = r_bit ? r_rd_one : r_rd_zero;
        tot   = {1'b0, r_rd_zero} + {1'b0, r_rd_one};
        n_cnt = (&cnt) ? cnt : cnt + COUNT_WIDTH'(1);
    end

    always_comb begin
        waddr   = r_sweep_busy ? r_sweep_idx : r_ctx;
        we_zero = r_sweep_busy || (fire_calc && !r_bit);
        we_one  = r_sweep_busy || (fire_calc && r_bit);
        wd_zero = r_sweep_busy ? r_sweep_base : n_cnt;
        wd_one  = r_sweep_busy ? r_sweep_base : n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (we_zero) begin
            r_zero_mem[waddr] <= wd_zero;
        end
        r_rd_zero <= r_zero_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_one) begin
            r_one_mem[waddr] <= wd_one;
        end
        r_rd_one <= r_one_mem[rd_addr];
    end

    // restore sweep after reset and on every new sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_busy <= 1'b1;
            r_sweep_idx  <= '0;
            r_sweep_base <= COUNT_WIDTH'(cbpe_pkg::INIT_COUNT_RST);
        end else if (pop && i_cls.new_sequence) begin
            r_sweep_busy <= 1'b1;
            r_sweep_idx  <= '0;
            r_sweep_base <= COUNT_WIDTH'(i_init_count);
        end else if (r_sweep_busy) begin
            if (r_sweep_idx == '1) begin
                r_sweep_busy <= 1'b0;
            end
            r_sweep_idx <= r_sweep_idx + CONTEXT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (pop && !i_cls.warm) begin
                        r_bit   <= i_cls.bit_value;
                        r_ctx   <= rd_addr;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (fire_calc) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (pop && i_cls.warm) begin
                r_job_valid <= 1'b1;
                r_job.warm  <= 1'b1;
                r_job.ctx   <= '0;
                r_job.cnt   <= '0;
                r_job.tot   <= '0;
            end else if (fire_calc) begin
                r_job_valid <= 1'b1;
                r_job.warm  <= 1'b0;
                r_job.ctx   <= cbpe_pkg::CTX_MAX_BITS'(r_ctx);
                r_job.cnt   <= cbpe_pkg::CNT_MAX_W'(cnt);
                r_job.tot   <= (cbpe_pkg::CNT_MAX_W + 1)'(tot);
            end else if (i_ready) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    assign o_job   = r_job;
    assign o_valid = r_job_valid;

endmodule

// File: rtl/cbpe_divider.sv
// ----------------------------------------------------------------------------
// cbpe_divider
// Rounded probability in hundredths of a percent by restoring division.
// ----------------------------------------------------------------------------
module cbpe_divider #(
    parameter int COUNT_WIDTH = cbpe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbpe_pkg::t_job      i_job,
    input  logic                i_valid,
    output logic                o_ready,
    output cbpe_pkg::t_out_item o_item,
    output logic                o_valid,
    input  logic                i_ready
);
    localparam int PW     = cbpe_pkg::PROB_W;
    localparam int TOT_W  = COUNT_WIDTH + 1;
    localparam int NUM_W  = COUNT_WIDTH + PW;
    localparam int STEP_W = $clog2(PW);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ADD, S_DIV, S_DONE
    } t_state;

    t_state                        r_state;
    logic                          r_warm;
    logic [cbpe_pkg::CTX_MAX_BITS-1:0] r_ctx;
    logic [COUNT_WIDTH-1:0]        r_cnt;
    logic [TOT_W-1:0]              r_tot;
    logic [NUM_W-1:0]              r_rem, r_dvs;
    logic [PW-1:0]                 r_quot;
    logic [STEP_W-1:0]             r_step;
    logic                          r_out_valid;
    cbpe_pkg::t_out_item           r_out;

    logic [COUNT_WIDTH-1:0]        job_cnt;
    logic [TOT_W-1:0]              job_tot;
    logic                          ge, out_free;

    assign o_ready  = r_state == S_IDLE;
    assign job_cnt  = COUNT_WIDTH'(i_job.cnt);
    assign job_tot  = TOT_W'(i_job.tot);
    assign ge       = r_rem >= r_dvs;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_warm <= i_job.warm;
                        r_ctx  <= i_job.ctx;
                        r_cnt  <= job_cnt;
                        r_tot  <= job_tot;
                        // no prediction, or both counts zero: report one half
                        if (i_job.warm || job_tot == '0) begin
                            r_quot  <= PW'(cbpe_pkg::PROB_HALF);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_rem   <= NUM_W'(r_cnt) * NUM_W'(cbpe_pkg::PROB_SCALE);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // half the divisor added for round to nearest
                    r_rem   <= r_rem + NUM_W'(r_tot >> 1);
                    r_dvs   <= NUM_W'(r_tot) << (PW - 1);
                    r_quot  <= '0;
                    r_step  <= STEP_W'(PW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (ge) begin
                        r_rem <= r_rem - r_dvs;
                    end
                    r_quot <= {r_quot[PW-2:0], ge};
                    r_dvs  <= r_dvs >> 1;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (r_state == S_DONE && out_free) begin
                r_out_valid                  <= 1'b1;
                r_out.probability_hundredths <= r_quot;
                r_out.warming_up             <= r_warm;
                r_out.context_code           <= cbpe_pkg::CTX_OUT_W'(r_ctx);
                r_out.count_of_digit         <= cbpe_pkg::CNT_OUT_W'(r_cnt);
                r_out.count_total            <= cbpe_pkg::TOT_OUT_W'(r_tot);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_item  = r_out;
    assign o_valid = r_out_valid;

endmodule

// File: rtl/context_bit_probability_estimator.sv
// ----------------------------------------------------------------------------
// context_bit_probability_estimator
// Order-k context model: predicts each binary digit from per-context counts.
// ----------------------------------------------------------------------------
//  channel    direction  handshake          payload
//  i_bit      in         valid / ready      bit_value, new_sequence
//  o_result   out        valid / ready      probability_hundredths, warming_up,
//                                           context_code, count_of_digit,
//                                           count_total
//  apb        in         psel/penable       initial_count at byte address 0
//
//  a warm-up item skips the count lookup and the division; a full-context item
//  is looked up in the count table and divided in the divider, which makes one
//  quotient bit per cycle and takes no new job until its result is registered
//  after reset and after each new_sequence item a restore sweep writes every
//  entry of the count memories; full-context items wait for it
//  a four-entry queue sits between the history front and the count table,
//  and the result register lets the divider finish while the output stalls
// ----------------------------------------------------------------------------
module context_bit_probability_estimator #(
    parameter int CONTEXT_BITS = cbpe_pkg::CONTEXT_BITS_DEF,
    parameter int COUNT_WIDTH  = cbpe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cbpe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cbpe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cbpe_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    cbpe_stream_if.sink                     i_bit,
    cbpe_stream_if.source                   o_result
);
    logic [cbpe_pkg::CFG_W-1:0] r_init_count;
    logic                       cfg_hit;

    cbpe_pkg::t_cls_item        front_cls, q_cls;
    logic                       front_valid, front_ready;
    logic                       q_valid, q_ready;
    cbpe_pkg::t_job             job;
    logic                       job_valid, job_ready;

    // configuration register
    assign pready  = 1'b1;
    assign cfg_hit = paddr[cbpe_pkg::APB_ADDR_W-1:2] == cbpe_pkg::REG_INITIAL_COUNT;
    assign prdata  = cfg_hit ? cbpe_pkg::APB_DATA_W'(r_init_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_count <= cbpe_pkg::INIT_COUNT_RST;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_init_count <= pwdata[cbpe_pkg::CFG_W-1:0];
        end
    end

    cbpe_front #(
        .CONTEXT_BITS (CONTEXT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_bit.payload),
        .i_valid (i_bit.valid),
        .o_ready (i_bit.ready),
        .o_cls   (front_cls),
        .o_valid (front_valid),
        .i_ready (front_ready)
    );

    cbpe_fifo #(
        .T     (cbpe_pkg::t_cls_item),
        .DEPTH (cbpe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (front_cls),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_data  (q_cls),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    cbpe_table #(
        .CONTEXT_BITS (CONTEXT_BITS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init_count (r_init_count),
        .i_cls        (q_cls),
        .i_valid      (q_valid),
        .o_ready      (q_ready),
        .o_job        (job),
        .o_valid      (job_valid),
        .i_ready      (job_ready)
    );

    cbpe_divider #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .i_valid (job_valid),
        .o_ready (job_ready),
        .o_item  (o_result.payload),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready)
    );

endmodule

// File: rtl/cbpe_checker.sv
// ----------------------------------------------------------------------------
// cbpe_checker
// Port-level checks of the estimator's result channel, bound to the top.
// ----------------------------------------------------------------------------
module cbpe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cbpe_pkg::t_out_item i_out_item
);

    // held result keeps its value while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_out_item.probability_hundredths <= cbpe_pkg::PROB_W'(cbpe_pkg::PROB_SCALE))
        else $error("probability above 100 percent");

    // warm-up results carry one half and no context or counts
    a_warm_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.warming_up |->
            i_out_item.probability_hundredths == cbpe_pkg::PROB_W'(cbpe_pkg::PROB_HALF) &&
            i_out_item.context_code == '0 &&
            i_out_item.count_of_digit == '0 &&
            i_out_item.count_total == '0)
        else $error("warm-up result with prediction fields set");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind context_bit_probability_estimator cbpe_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_item  (o_result.payload)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams binary digits through the context bit probability estimator and
// checks every result against a cycle-free model of the per-context counts:
// warm-up, restarts, zero starting counts and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CTX_BITS      = cbpe_pkg::CONTEXT_BITS_DEF;
    localparam int CNT_W         = cbpe_pkg::COUNT_WIDTH_DEF;
    localparam int NCTX          = 1 << CTX_BITS;
    localparam longint CNT_MAX   = (longint'(1) << CNT_W) - 1;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam logic [cbpe_pkg::APB_ADDR_W-1:0] INIT_ADDR =
        {cbpe_pkg::REG_INITIAL_COUNT, 2'b00};

    // model of the count tables and the queue of probabilities still due
    class bit_odds_board;
        bit [7:0]            start_count;
        bit [CTX_BITS-1:0]   history;
        int                  fill;
        bit [CNT_W-1:0]      zeros [NCTX];
        bit [CNT_W-1:0]      ones  [NCTX];
        cbpe_pkg::t_out_item due [$];
        int                  mismatches;

        function new();
            start_count = cbpe_pkg::INIT_COUNT_RST;
            mismatches  = 0;
            restart();
        endfunction

        function void restart();
            for (int c = 0; c < NCTX; c++) begin
                zeros[c] = CNT_W'(start_count);
                ones[c]  = CNT_W'(start_count);
            end
            history = '0;
            fill    = 0;
        endfunction

        task report(string what, longint got, longint want);
            if (mismatches < 40) begin
                $display("mismatch %s: got %0d, expected %0d", what, got, want);
            end
            mismatches++;
        endtask

        task note_digit(cbpe_pkg::t_in_item it);
            cbpe_pkg::t_out_item want;
            bit [CTX_BITS-1:0]   ctx;
            longint unsigned     mine;
            longint unsigned     total;
            if (it.new_sequence) restart();
            want = '0;
            want.probability_hundredths = cbpe_pkg::PROB_W'(cbpe_pkg::PROB_HALF);
            want.warming_up = 1'b1;
            if (fill >= CTX_BITS) begin
                ctx   = history;
                mine  = it.bit_value ? ones[ctx] : zeros[ctx];
                total = longint'(zeros[ctx]) + longint'(ones[ctx]);
                if (total != 0) begin
                    want.probability_hundredths = cbpe_pkg::PROB_W'(
                        (mine * cbpe_pkg::PROB_SCALE + total / 2) / total);
                end
                want.warming_up     = 1'b0;
                want.context_code   = cbpe_pkg::CTX_OUT_W'(ctx);
                want.count_of_digit = cbpe_pkg::CNT_OUT_W'(mine);
                want.count_total    = cbpe_pkg::TOT_OUT_W'(total);
                if (mine < CNT_MAX) begin
                    if (it.bit_value) ones[ctx]++;
                    else zeros[ctx]++;
                end
            end else begin
                fill++;
            end
            history = {it.bit_value, history[CTX_BITS-1:1]};
            due.push_back(want);
        endtask

        task check_odds(cbpe_pkg::t_out_item got);
            cbpe_pkg::t_out_item want;
            if (due.size() == 0) begin
                report("result with nothing due", got.probability_hundredths, 0);
                return;
            end
            want = due.pop_front();
            if (got.probability_hundredths !== want.probability_hundredths)
                report("probability_hundredths", got.probability_hundredths,
                       want.probability_hundredths);
            if (got.warming_up !== want.warming_up)
                report("warming_up", got.warming_up, want.warming_up);
            if (got.context_code !== want.context_code)
                report("context_code", got.context_code, want.context_code);
            if (got.count_of_digit !== want.count_of_digit)
                report("count_of_digit", got.count_of_digit, want.count_of_digit);
            if (got.count_total !== want.count_total)
                report("count_total", got.count_total, want.count_total);
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [cbpe_pkg::APB_ADDR_W-1:0] paddr;
    logic [cbpe_pkg::APB_DATA_W-1:0] pwdata;
    logic [cbpe_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    cbpe_stream_if #(.T(cbpe_pkg::t_in_item))  bit_ch ();
    cbpe_stream_if #(.T(cbpe_pkg::t_out_item)) res_ch ();

    bit_odds_board sb;
    bit            idle_on;
    int            rx_stall;
    int            rx_hold;
    int            quiet_cycles;

    // digit pattern of the current sequence
    int            pat_mode;
    bit [7:0]      pat_bits;
    int            pat_len;
    int            pat_pos;
    bit            lean_bit;

    always #2 i_clk = ~i_clk;

    context_bit_probability_estimator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_bit    (bit_ch),
        .o_result (res_ch)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function void new_pattern();
        pat_mode = $urandom_range(0, 2);
        pat_bits = 8'($urandom);
        pat_len  = $urandom_range(1, 6);
        pat_pos  = 0;
        lean_bit = 1'($urandom_range(0, 1));
    endfunction

    function bit next_digit();
        bit b;
        case (pat_mode)
            0: begin
                b = 1'($urandom_range(0, 1));
            end
            1: begin
                b = ($urandom_range(0, 9) < 8) ? lean_bit : !lean_bit;
            end
            default: begin
                b = pat_bits[pat_pos % pat_len];
                pat_pos++;
                if ($urandom_range(0, 9) == 0) b = !b;
            end
        endcase
        return b;
    endfunction

    // accepted items on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (bit_ch.valid && bit_ch.ready) sb.note_digit(bit_ch.payload);
            if (res_ch.valid && res_ch.ready) sb.check_odds(res_ch.payload);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (bit_ch.valid && bit_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result receiver: random stalls plus a long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                res_ch.ready <= 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                res_ch.ready <= 1'b0;
                rx_stall--;
            end else begin
                res_ch.ready <= 1'b1;
                if (idle_on) rx_stall = pick_gap();
            end
        end
    end

    task automatic send_digit(bit b, bit ns);
        cbpe_pkg::t_in_item it;
        int                 gap;
        it.bit_value    = b;
        it.new_sequence = ns;
        gap = idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            bit_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        bit_ch.valid   <= 1'b1;
        bit_ch.payload <= it;
        do @(posedge i_clk); while (!bit_ch.ready);
    endtask

    // wait for every due result and for the restore sweep to finish
    task automatic settle();
        @(negedge i_clk);
        bit_ch.valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_initial_count(bit [7:0] v);
        logic [cbpe_pkg::APB_DATA_W-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INIT_ADDR;
        pwdata  <= cbpe_pkg::APB_DATA_W'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.start_count = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== cbpe_pkg::APB_DATA_W'(v)) sb.report("initial_count readback", rd, v);
    endtask

    task automatic run_random(int n, bit with_pressure);
        int k;
        bit ns;
        new_pattern();
        for (k = 0; k < n; k++) begin
            if (k % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (with_pressure && k == 40) begin
                // hold the output long enough to back the block up
                rx_hold = 300;
                idle_on = 1'b0;
            end
            if (with_pressure && k == 90) idle_on = 1'b1;
            ns = (k == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
            if (ns) new_pattern();
            send_digit(next_digit(), ns);
        end
    endtask

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        bit_ch.valid = 1'b0;
        bit_ch.payload = '0;
        idle_on      = 1'b1;
        rx_stall     = 0;
        rx_hold      = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // warm-up from reset, then both digits in full contexts
        send_digit(1'b1, 1'b0);
        send_digit(1'b1, 1'b0);
        send_digit(1'b0, 1'b0);
        send_digit(1'b0, 1'b0);
        send_digit(1'b1, 1'b0);
        send_digit(1'b1, 1'b0);
        send_digit(1'b0, 1'b0);
        send_digit(1'b1, 1'b0);
        send_digit(1'b1, 1'b0);
        // restart mid-stream, then again while still warming up
        send_digit(1'b0, 1'b1);
        send_digit(1'b1, 1'b1);
        repeat (4) send_digit(1'b1, 1'b0);
        send_digit(1'b0, 1'b0);
        settle();

        // zero starting counts: old counts stay until the next restart
        set_initial_count(8'd0);
        send_digit(1'b0, 1'b0);
        send_digit(1'b1, 1'b0);
        send_digit(1'b0, 1'b1);
        repeat (3) send_digit(1'b0, 1'b0);
        send_digit(1'b0, 1'b0);
        send_digit(1'b0, 1'b0);
        send_digit(1'b1, 1'b0);
        settle();

        set_initial_count(8'd255);
        run_random(135, 1'b0);
        settle();
        set_initial_count(8'd1);
        run_random(135, 1'b0);
        settle();
        set_initial_count(8'($urandom_range(2, 254)));
        run_random(135, 1'b1);
        settle();
        set_initial_count(8'($urandom_range(1, 255)));
        run_random(135, 1'b0);
        settle();
        set_initial_count(8'($urandom_range(1, 20)));
        run_random(135, 1'b0);
        settle();

        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cbpe_pkg.sv
rtl/cbpe_stream_if.sv
rtl/cbpe_front.sv
rtl/cbpe_fifo.sv
rtl/cbpe_table.sv
rtl/cbpe_divider.sv
rtl/context_bit_probability_estimator.sv
rtl/cbpe_checker.sv
dv/testbench.sv
